FILE: design/cva_pkg.sv
// ----------------------------------------------------------------------------
// cva_pkg
// Shared types and codes for the client vote aggregator.
// ----------------------------------------------------------------------------
package cva_pkg;

    typedef enum logic [1:0] {
        ACT_VOTE     = 2'd0,
        ACT_OVERRIDE = 2'd1,
        ACT_MAP_ADD  = 2'd2,
        ACT_QUERY    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_MAP_ERR = 2'd2
    } status_t;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;

    localparam logic [1:0] SRC_ELECTED  = 2'd0;
    localparam logic [1:0] SRC_OVERRIDE = 2'd1;

    localparam logic [1:0] REG_VOTE_MODE   = 2'd0;
    localparam logic [1:0] REG_FORCE_ON    = 2'd1;
    localparam logic [1:0] REG_FORCE_VALUE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAPSCAN,
        S_SCAN,
        S_LOOKUP,
        S_FINISH,
        S_OUT
    } state_t;

endpackage

FILE: design/client_vote_aggregator_core.sv
// ----------------------------------------------------------------------------
// client_vote_aggregator_core
// Per-client vote store with serial min/max/any election and value map.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item per action. in_stall is high
// while an item is being worked; the block takes one item at a time.
// Output channel (out_valid/out_stall): one result item per input item. The
// result is held in an output register until taken; no new item is taken
// before it leaves.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready.
// Vote and query scan every client in turn, and each known enabled client in
// min/max also walks the map table before its compare; in set-any mode, or
// for a client that is not a candidate, the scan only steps on. Map add walks
// the map table, stopping early on a duplicate; override goes straight to the
// finish step. No new item is taken before the last result has left. The
// shared unit is one 32-bit comparator, used once a cycle by the map walk and
// the election scan.
// Reset clears all votes and values, the known bits, the map-used bits, the
// override and the registers. A stall on the output holds the result and
// blocks the next input item.
// ----------------------------------------------------------------------------
module client_vote_aggregator_core #(
    parameter int CLIENTS     = 32,
    parameter int MAP_ENTRIES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [4:0]         client,
    input  logic               enable,
    input  logic signed [31:0] amount,
    input  logic signed [31:0] mapped_amount,
    input  logic               step_flag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               notify,
    output logic signed [31:0] notify_value,
    output logic               notify_valid,
    output logic [1:0]         notify_source,
    output logic [4:0]         notify_client,
    output logic               notify_step,
    output logic signed [31:0] result_value,
    output logic               result_valid,
    output logic [4:0]         result_client,
    output logic signed [31:0] query_value,
    output logic               query_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    // Configuration registers
    logic [1:0]  vote_mode_reg;
    logic        force_on_reg;
    logic [30:0] force_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_mode_reg   <= 2'd0;
            force_on_reg    <= 1'b0;
            force_value_reg <= 31'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cva_pkg::REG_VOTE_MODE:   vote_mode_reg   <= cfg_data[1:0];
                cva_pkg::REG_FORCE_ON:    force_on_reg    <= cfg_data[0];
                cva_pkg::REG_FORCE_VALUE: force_value_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    wire any_mode = (vote_mode_reg != cva_pkg::MODE_MIN) &&
                    (vote_mode_reg != cva_pkg::MODE_MAX);

    // Stores
    logic [CLIENTS-1:0]            vote_on_reg;
    logic [CLIENTS-1:0]            known_reg;
    logic signed [31:0]            vote_amount_reg [CLIENTS];
    logic [MAP_ENTRIES-1:0]        map_used_reg;
    logic signed [31:0]            map_from_reg [MAP_ENTRIES];
    logic signed [31:0]            map_to_reg [MAP_ENTRIES];

    // Persistent election state
    logic               any_voted_reg;
    logic signed [31:0] elected_amount_reg;
    logic               elected_valid_reg;
    logic [4:0]         elected_index_reg;
    logic               override_on_reg;
    logic signed [31:0] override_amount_reg;
    logic [4:0]         override_index_reg;

    // Latched item
    logic [1:0]         act_reg;
    logic [4:0]         cli_reg;
    logic               en_reg;
    logic signed [31:0] amt_reg;
    logic signed [31:0] mam_reg;
    logic               step_reg;
    logic               same_pre_reg;

    // Scan state
    cva_pkg::state_t    state_reg, state_next;
    logic [CW:0]        ci_reg;
    logic [MW:0]        mi_reg;
    logic               found_reg;
    logic signed [31:0] best_reg;
    logic [CW-1:0]      bi_reg;
    logic               anyor_reg;
    logic               freeseen_reg;
    logic [MW-1:0]      free_reg;
    logic               dup_reg;
    logic signed [31:0] cand_reg;   // mapped value being looked up

    // Output register
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic               notify_reg;
    logic signed [31:0] nval_reg;
    logic               nvalid_reg;
    logic [1:0]         nsrc_reg;
    logic [4:0]         ncli_reg;
    logic               nstep_reg;
    logic signed [31:0] rval_reg;
    logic               rvalid_reg;
    logic [4:0]         rcli_reg;
    logic signed [31:0] qval_reg;
    logic               qvalid_reg;

    wire accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != cva_pkg::S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;

    wire [CW-1:0] ci  = ci_reg[CW-1:0];
    wire [MW-1:0] mi  = mi_reg[MW-1:0];
    wire ci_last = (ci_reg == (CW+1)'(CLIENTS - 1));
    wire mi_last = (mi_reg == (MW+1)'(MAP_ENTRIES - 1));

    wire excl_hit = (act_reg == cva_pkg::ACT_QUERY) &&
                    ((CW+5)'(cli_reg) == (CW+5)'(ci));
    wire cand = known_reg[ci] && vote_on_reg[ci] && !excl_hit;

    // Shared comparator: map key match, or election best compare
    logic signed [31:0] cmp_a, cmp_b;
    always_comb
    begin
        if (state_reg == cva_pkg::S_MAPSCAN)
        begin
            cmp_a = map_from_reg[mi];
            cmp_b = amt_reg;
        end
        else if (state_reg == cva_pkg::S_LOOKUP)
        begin
            cmp_a = map_from_reg[mi];
            cmp_b = vote_amount_reg[ci];
        end
        else
        begin
            cmp_a = cand_reg;
            cmp_b = best_reg;
        end
    end
    wire cmp_eq = (cmp_a == cmp_b);
    wire cmp_lt = (cmp_a < cmp_b);
    wire better = !found_reg ||
                  ((vote_mode_reg == cva_pkg::MODE_MIN) ? cmp_lt : (!cmp_lt && !cmp_eq));

    // Client index checks for the latched and the incoming item
    wire               cli_ok = ({27'd0, cli_reg} < 32'(CLIENTS));
    wire [CW-1:0]      cli_in = CW'(client);
    wire               in_ok  = ({27'd0, client} < 32'(CLIENTS));
    wire signed [31:0] in_v   = any_mode ? {31'd0, enable} : amount;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cva_pkg::S_IDLE:
                if (accept_in)
                begin
                    case (action)
                        cva_pkg::ACT_MAP_ADD:  state_next = cva_pkg::S_MAPSCAN;
                        cva_pkg::ACT_OVERRIDE: state_next = cva_pkg::S_FINISH;
                        default:               state_next = cva_pkg::S_SCAN;
                    endcase
                end
            cva_pkg::S_MAPSCAN:
                if (mi_last || (map_used_reg[mi] && cmp_eq))
                    state_next = cva_pkg::S_FINISH;
            cva_pkg::S_SCAN:
                if (any_mode || !cand)
                begin
                    if (ci_last)
                        state_next = cva_pkg::S_FINISH;
                end
                else
                    state_next = cva_pkg::S_LOOKUP;
            cva_pkg::S_LOOKUP:
                if (mi_last || (map_used_reg[mi] && cmp_eq))
                    state_next = cva_pkg::S_OUT;
            cva_pkg::S_OUT:
                state_next = ci_last ? cva_pkg::S_FINISH : cva_pkg::S_SCAN;
            cva_pkg::S_FINISH:
                state_next = cva_pkg::S_IDLE;
            default:
                state_next = cva_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cva_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Item latch and map stores (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            act_reg  <= action;
            cli_reg  <= client;
            en_reg   <= enable;
            amt_reg  <= amount;
            mam_reg  <= mapped_amount;
            step_reg <= step_flag;
        end
        if (state_reg == cva_pkg::S_FINISH && act_reg == cva_pkg::ACT_MAP_ADD &&
            !dup_reg && freeseen_reg)
        begin
            map_from_reg[free_reg] <= amt_reg;
            map_to_reg[free_reg]   <= mam_reg;
        end
    end

    // Scan datapath: map walk and election candidates
    logic signed [31:0] e_val;
    logic               e_valid;
    logic [4:0]         e_idx;
    always_comb
    begin
        if (any_mode)
        begin
            e_valid = 1'b1;
            e_val   = {31'd0, anyor_reg};
            e_idx   = 5'd0;
        end
        else
        begin
            e_valid = found_reg;
            e_val   = found_reg ? vote_amount_reg[bi_reg] : 32'sd0;
            e_idx   = found_reg ? 5'(bi_reg) : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg       <= '0;
            mi_reg       <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            bi_reg       <= '0;
            anyor_reg    <= 1'b0;
            freeseen_reg <= 1'b0;
            free_reg     <= '0;
            dup_reg      <= 1'b0;
            cand_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                cva_pkg::S_IDLE:
                begin
                    ci_reg       <= '0;
                    mi_reg       <= '0;
                    found_reg    <= 1'b0;
                    anyor_reg    <= 1'b0;
                    freeseen_reg <= 1'b0;
                    dup_reg      <= 1'b0;
                end
                cva_pkg::S_MAPSCAN:
                begin
                    mi_reg <= mi_reg + 1'b1;
                    if (map_used_reg[mi] && cmp_eq)
                        dup_reg <= 1'b1;
                    else if (!map_used_reg[mi] && !freeseen_reg)
                    begin
                        freeseen_reg <= 1'b1;
                        free_reg     <= mi;
                    end
                end
                cva_pkg::S_SCAN:
                begin
                    mi_reg <= '0;
                    if (any_mode || !cand)
                    begin
                        if (cand)
                            anyor_reg <= 1'b1;
                        ci_reg <= ci_reg + 1'b1;
                    end
                    else
                        cand_reg <= vote_amount_reg[ci];
                end
                cva_pkg::S_LOOKUP:
                begin
                    mi_reg <= mi_reg + 1'b1;
                    if (map_used_reg[mi] && cmp_eq)
                        cand_reg <= map_to_reg[mi];
                end
                cva_pkg::S_OUT:
                begin
                    if (better)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= cand_reg;
                        bi_reg    <= ci;
                    end
                    ci_reg <= ci_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Commit: stores, election state and the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_on_reg         <= '0;
            known_reg           <= '0;
            map_used_reg        <= '0;
            any_voted_reg       <= 1'b0;
            elected_amount_reg  <= '0;
            elected_valid_reg   <= 1'b0;
            elected_index_reg   <= '0;
            override_on_reg     <= 1'b0;
            override_amount_reg <= '0;
            override_index_reg  <= '0;
            out_valid_reg       <= 1'b0;
            status_reg          <= '0;
            notify_reg          <= 1'b0;
            nval_reg            <= '0;
            nvalid_reg          <= 1'b0;
            nsrc_reg            <= '0;
            ncli_reg            <= '0;
            nstep_reg           <= 1'b0;
            rval_reg            <= '0;
            rvalid_reg          <= 1'b0;
            rcli_reg            <= '0;
            qval_reg            <= '0;
            qvalid_reg          <= 1'b0;
            for (int i = 0; i < CLIENTS; i++)
                vote_amount_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // A vote's store update happens at accept time in a pre-pass:
            // the item is written on entering the scan so the scan sees it.
            if (state_reg == cva_pkg::S_IDLE && accept_in && action == cva_pkg::ACT_VOTE &&
                in_ok)
            begin
                known_reg[cli_in] <= 1'b1;
                if (!(any_voted_reg && (vote_on_reg[cli_in] == enable) &&
                      (vote_amount_reg[cli_in] == in_v)))
                begin
                    vote_on_reg[cli_in]     <= enable;
                    vote_amount_reg[cli_in] <= in_v;
                end
            end

            if (state_reg == cva_pkg::S_FINISH)
            begin
                logic               n;
                logic signed [31:0] nv;
                logic               nvd;
                logic [1:0]         ns;
                logic [4:0]         nc;
                logic [1:0]         st;
                logic               ov_on;
                logic signed [31:0] ov_amt;
                logic               ev_nv;
                logic signed [31:0] ev_am;
                logic [4:0]         ev_ix;
                logic signed [31:0] qv;
                logic               qd;
                n = 1'b0; nv = '0; nvd = 1'b0; ns = cva_pkg::SRC_ELECTED; nc = '0;
                st = cva_pkg::ST_APPLIED;
                ov_on  = override_on_reg;
                ov_amt = override_amount_reg;
                ev_nv  = elected_valid_reg;
                ev_am  = elected_amount_reg;
                ev_ix  = elected_index_reg;
                qv = '0; qd = 1'b0;
                case (act_reg)
                    cva_pkg::ACT_VOTE:
                    begin
                        if (!cli_ok)
                            st = cva_pkg::ST_IGNORED;
                        else if (same_pre_reg && any_voted_reg)
                            st = cva_pkg::ST_IGNORED;
                        else
                        begin
                            logic [4:0] ei;
                            ei = any_mode ? cli_reg : e_idx;
                            if (!any_voted_reg || (e_valid != elected_valid_reg) ||
                                (e_val != elected_amount_reg))
                            begin
                                ev_nv = e_valid; ev_am = e_val;
                                if (!force_on_reg && !override_on_reg)
                                begin
                                    n = 1'b1; nv = e_val; nvd = e_valid; nc = ei;
                                end
                            end
                            ev_ix = ei;
                            any_voted_reg <= 1'b1;
                        end
                    end
                    cva_pkg::ACT_OVERRIDE:
                    begin
                        if (force_on_reg)
                        begin
                            ov_on = en_reg;
                            if (en_reg)
                                ov_amt = amt_reg;
                        end
                        else if (en_reg)
                        begin
                            n = 1'b1; nv = amt_reg; nvd = 1'b1;
                            ns = cva_pkg::SRC_OVERRIDE; nc = cli_reg;
                            ov_on = 1'b1; ov_amt = amt_reg;
                            override_index_reg <= cli_reg;
                        end
                        else
                        begin
                            n = 1'b1; nv = elected_amount_reg;
                            nvd = elected_valid_reg || any_mode;
                            nc = elected_index_reg;
                            ov_on = 1'b0;
                        end
                    end
                    cva_pkg::ACT_MAP_ADD:
                    begin
                        if (dup_reg || !freeseen_reg)
                            st = cva_pkg::ST_MAP_ERR;
                        else
                            map_used_reg[free_reg] <= 1'b1;
                    end
                    default:
                    begin
                        if (force_on_reg)
                        begin
                            qv = {1'b0, force_value_reg}; qd = 1'b1;
                        end
                        else if (override_on_reg)
                        begin
                            qv = override_amount_reg; qd = 1'b1;
                        end
                        else
                        begin
                            qv = e_val; qd = e_valid;
                        end
                    end
                endcase
                override_on_reg     <= ov_on;
                override_amount_reg <= ov_amt;
                elected_valid_reg   <= ev_nv;
                elected_amount_reg  <= ev_am;
                elected_index_reg   <= ev_ix;

                out_valid_reg <= 1'b1;
                status_reg    <= st;
                notify_reg    <= n;
                nval_reg      <= nv;
                nvalid_reg    <= nvd;
                nsrc_reg      <= ns;
                ncli_reg      <= nc;
                nstep_reg     <= n & step_reg;
                rcli_reg      <= ev_ix;
                qval_reg      <= qv;
                qvalid_reg    <= qd;
                if (force_on_reg)
                begin
                    rval_reg <= {1'b0, force_value_reg}; rvalid_reg <= 1'b1;
                end
                else if (ov_on)
                begin
                    rval_reg <= ov_amt; rvalid_reg <= 1'b1;
                end
                else
                begin
                    rval_reg <= ev_am; rvalid_reg <= ev_nv || any_mode;
                end
            end
        end
    end

    // Identical-vote flag taken against the store before the vote writes it
    always_ff @(posedge clk)
    begin
        if (accept_in)
            same_pre_reg <= in_ok && (vote_on_reg[cli_in] == enable) &&
                            (vote_amount_reg[cli_in] == in_v);
    end

    assign status        = status_reg;
    assign notify        = notify_reg;
    assign notify_value  = nval_reg;
    assign notify_valid  = nvalid_reg;
    assign notify_source = nsrc_reg;
    assign notify_client = ncli_reg;
    assign notify_step   = nstep_reg;
    assign result_value  = rval_reg;
    assign result_valid  = rvalid_reg;
    assign result_client = rcli_reg;
    assign query_value   = qval_reg;
    assign query_valid   = qvalid_reg;

`ifndef SYNTH
    // No item is taken while a result is still waiting
    assert property (@(posedge clk) disable iff (!rst_n) out_valid_reg |-> in_stall)
        else $error("input accepted with pending result");
    // A result appears only after the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cva_pkg::S_FINISH))
        else $error("result without finish");
    // Notify carries zero payload fields when not raised
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !notify_reg) |-> (nval_reg == 32'sd0 && !nvalid_reg))
        else $error("notify payload without notify");
    // Force always yields a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && $rose(out_valid_reg) && $past(force_on_reg)) |-> rvalid_reg)
        else $error("force result not valid");
`endif

endmodule
